// ===== rtl/pcf_pkg.sv =====
// Package for the per-channel command FIFO: sizes, codes and control structs.
`default_nettype none
package pcf_pkg;

	localparam int CHANNELS   = 4;
	localparam int DEPTH      = 64;
	localparam int WORD_WIDTH = 64;

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int MEM_DEPTH = CHANNELS * DEPTH;
	localparam int ADDR_W = $clog2(MEM_DEPTH);

	// fixed field widths of the ports
	localparam int FUNC_W = 3;
	localparam int QID_W  = 8;
	localparam int XWORD_W = 64;
	localparam int STAT_W = 2;
	localparam int CAP_W  = 11;

	localparam logic [CAP_W-1:0] CAPACITY = CAP_W'(DEPTH);

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH  = 3'd0,
		FN_POP   = 3'd1,
		FN_PEEK  = 3'd2,
		FN_CLEAR = 3'd3,
		FN_QUERY = 3'd4
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_BAD   = 2'd3
	} stat_t;

	// controller -> datapath
	typedef struct packed {
		logic start;    // transaction accepted this cycle, execute it
		logic capture;  // RAM read data is ready, latch it
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic rd_issue; // accepted command reads the word RAM
	} sts_t;

	function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/pcf_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none
module pcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/pcf_ctrl.sv =====
// Controller: sequences accept, optional RAM read wait, and result handoff.
`default_nettype none
module pcf_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire logic         out_ready,
	output pcf_pkg::cmd_t     cmd,
	input  wire pcf_pkg::sts_t sts
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WAIT,
		S_RESP
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	always_comb begin
		cmd.start   = in_valid && in_ready_q;
		cmd.capture = (state_q == S_WAIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						in_ready_q <= 1'b0;
						if (sts.rd_issue) begin
							state_q <= S_WAIT;
						end else begin
							state_q     <= S_RESP;
							out_valid_q <= 1'b1;
						end
					end
				end
				S_WAIT: begin
					state_q     <= S_RESP;
					out_valid_q <= 1'b1;
				end
				S_RESP: begin
					if (out_ready) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b0;
						in_ready_q  <= 1'b1;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					in_ready_q  <= 1'b1;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/pcf_dp.sv =====
// Datapath: per-channel pointers and counts, word RAM, result registers.
`default_nettype none
module pcf_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pcf_pkg::cmd_t                 cmd,
	output pcf_pkg::sts_t                      sts,
	input  wire logic [pcf_pkg::FUNC_W-1:0]    func,
	input  wire logic [pcf_pkg::QID_W-1:0]     queue_id,
	input  wire logic [pcf_pkg::XWORD_W-1:0]   push_word,
	output logic      [pcf_pkg::STAT_W-1:0]    status,
	output logic      [pcf_pkg::XWORD_W-1:0]   read_word,
	output logic                               read_valid,
	output logic                               is_empty,
	output logic                               is_full,
	output logic      [pcf_pkg::CAP_W-1:0]     capacity
);

	logic [pcf_pkg::PTR_W-1:0] head_q [pcf_pkg::CHANNELS];
	logic [pcf_pkg::PTR_W-1:0] tail_q [pcf_pkg::CHANNELS];
	logic [pcf_pkg::CNT_W-1:0] fill_q [pcf_pkg::CHANNELS];

	logic                        chan_ok;
	logic [pcf_pkg::CH_W-1:0]    chan;
	logic [pcf_pkg::CNT_W-1:0]   cnt, new_cnt;
	logic [pcf_pkg::PTR_W-1:0]   hd, tl, new_head, new_tail;
	logic [pcf_pkg::ADDR_W-1:0]  base, ram_addr;
	pcf_pkg::stat_t              st;
	logic                        do_wr, do_rd;
	logic [pcf_pkg::WORD_WIDTH-1:0] ram_rdata;

	logic [pcf_pkg::STAT_W-1:0]  status_q;
	logic [pcf_pkg::XWORD_W-1:0] rword_q;
	logic                        rvalid_q, empty_q, full_q;
	logic [pcf_pkg::CAP_W-1:0]   cap_q;

	always_comb begin
		chan_ok  = queue_id < pcf_pkg::QID_W'(pcf_pkg::CHANNELS);
		chan     = queue_id[pcf_pkg::CH_W-1:0];
		cnt      = fill_q[chan];
		hd       = head_q[chan];
		tl       = tail_q[chan];
		new_cnt  = cnt;
		new_head = hd;
		new_tail = tl;
		st       = pcf_pkg::ST_OK;
		do_wr    = 1'b0;
		do_rd    = 1'b0;
		case (pcf_pkg::func_t'(func))
			pcf_pkg::FN_PUSH: begin
				if (cnt < pcf_pkg::CNT_W'(pcf_pkg::DEPTH)) begin
					new_tail = pcf_pkg::next_pos(tl);
					new_cnt  = cnt + pcf_pkg::CNT_W'(1);
					do_wr    = 1'b1;
				end else begin
					st = pcf_pkg::ST_FULL;
				end
			end
			pcf_pkg::FN_POP, pcf_pkg::FN_PEEK: begin
				if (cnt != '0) begin
					do_rd = 1'b1;
					if (pcf_pkg::func_t'(func) == pcf_pkg::FN_POP) begin
						new_head = pcf_pkg::next_pos(hd);
						new_cnt  = cnt - pcf_pkg::CNT_W'(1);
					end
				end else begin
					st = pcf_pkg::ST_EMPTY;
				end
			end
			pcf_pkg::FN_CLEAR: begin
				new_head = pcf_pkg::next_pos(tl);
				new_cnt  = '0;
			end
			default: begin
			end
		endcase
		if (!chan_ok) begin
			st    = pcf_pkg::ST_BAD;
			do_wr = 1'b0;
			do_rd = 1'b0;
		end
		// channel region base: channel times depth
		base     = pcf_pkg::ADDR_W'(chan) * pcf_pkg::ADDR_W'(pcf_pkg::DEPTH);
		ram_addr = base + pcf_pkg::ADDR_W'(do_wr ? new_tail : hd);
	end

	always_comb begin
		sts.rd_issue = do_rd;
	end

	pcf_ram #(
		.WIDTH(pcf_pkg::WORD_WIDTH),
		.DEPTH(pcf_pkg::MEM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.start && do_wr),
		.re   (cmd.start && do_rd),
		.addr (ram_addr),
		.wdata(push_word[pcf_pkg::WORD_WIDTH-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pcf_pkg::CHANNELS; i++) begin
				head_q[i] <= pcf_pkg::next_pos('0);
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else if (cmd.start && chan_ok) begin
			head_q[chan] <= new_head;
			tail_q[chan] <= new_tail;
			fill_q[chan] <= new_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			status_q <= st;
			rvalid_q <= do_rd;
			rword_q  <= '0;
			empty_q  <= chan_ok ? (new_cnt == '0) : 1'b1;
			full_q   <= chan_ok ? (new_cnt == pcf_pkg::CNT_W'(pcf_pkg::DEPTH)) : 1'b1;
			cap_q    <= chan_ok ? pcf_pkg::CAPACITY : '0;
		end else if (cmd.capture) begin
			rword_q <= pcf_pkg::XWORD_W'(ram_rdata);
		end
	end

	assign status     = status_q;
	assign read_word  = rword_q;
	assign read_valid = rvalid_q;
	assign is_empty   = empty_q;
	assign is_full    = full_q;
	assign capacity   = cap_q;

endmodule
`default_nettype wire

// ===== rtl/per_channel_command_fifo.sv =====
// Top level of the per-channel command FIFO.
// A set of independent circular command FIFOs, one per channel, sharing a single word RAM
// of CHANNELS x DEPTH entries. One transaction is handled at a time: in_ready drops when
// a command is accepted and returns the cycle after its result has been taken. Push,
// clear, status query and any command naming an invalid channel offer their result in
// the cycle after accept; a successful pop or peek offers it in the cycle after that, the
// extra S_WAIT state being the registered read of the single-port word RAM. The RAM
// holds no reset state; pops and peeks only ever read entries a push has written.
`default_nettype none
module per_channel_command_fifo (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [pcf_pkg::FUNC_W-1:0]  func,
	input  wire logic [pcf_pkg::QID_W-1:0]   queue_id,
	input  wire logic [pcf_pkg::XWORD_W-1:0] push_word,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [pcf_pkg::STAT_W-1:0]  status,
	output logic      [pcf_pkg::XWORD_W-1:0] read_word,
	output logic                             read_valid,
	output logic                             is_empty,
	output logic                             is_full,
	output logic      [pcf_pkg::CAP_W-1:0]   capacity
);

	pcf_pkg::cmd_t cmd;
	pcf_pkg::sts_t sts;

	pcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	pcf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.func      (func),
		.queue_id  (queue_id),
		.push_word (push_word),
		.status    (status),
		.read_word (read_word),
		.read_valid(read_valid),
		.is_empty  (is_empty),
		.is_full   (is_full),
		.capacity  (capacity)
	);

	// one transaction in flight: never ready for input while a result is offered
	assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input ready while result pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction accepted while one is in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |-> status == pcf_pkg::ST_OK)
		else $error("read word flagged on a failed command");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pcf_pkg::ST_BAD |->
			is_empty && is_full && capacity == '0 && !read_valid)
		else $error("invalid channel result fields wrong");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_full && status != pcf_pkg::ST_BAD |-> !is_empty)
		else $error("valid channel both empty and full");

endmodule
`default_nettype wire
